// File: rtl/core/dotq_pkg.sv
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and codes of the deadline-ordered timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

    // Result kinds as they appear on the result port
    localparam logic [2:0] RK_DUE    = 3'd0;
    localparam logic [2:0] RK_ARMED  = 3'd1;
    localparam logic [2:0] RK_QUEUED = 3'd2;
    localparam logic [2:0] RK_EMPTY  = 3'd3;
    localparam logic [2:0] RK_REJECT = 3'd4;

    // Input kind codes
    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_SVC = 2'd1;
    localparam logic [1:0] KIND_CAN = 2'd2;

    localparam int CLICK_BITS = 16;
    localparam int ID_BITS    = 4;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_SVC,
        OP_CAN,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_BITS-1:0] id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [ID_BITS-1:0]    id;
        logic [CLICK_BITS-1:0] cmp;
        logic                  last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SERVICE,
        ST_REQUEUE
    } state_t;

endpackage

// File: rtl/core/dotq_front.sv
// ----------------------------------------------------------------------------
// dotq_front
// Accepts input beats, decodes the kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dotq_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   kind,
    input  logic [dotq_pkg::ID_BITS-1:0] task_id,
    input  logic [TIME_BITS-1:0]         due_time,
    input  logic [TIME_BITS-1:0]         current_time,
    output logic                         cmd_valid,
    output dotq_pkg::cmd_t               cmd,
    output logic [TIME_BITS-1:0]         cmd_due,
    output logic [TIME_BITS-1:0]         cmd_now,
    input  logic                         cmd_take
);
    import dotq_pkg::*;

    cmd_t                 q_cmd_reg [2];
    logic [TIME_BITS-1:0] q_due_reg [2];
    logic [TIME_BITS-1:0] q_now_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 do_wr, do_rd;
    cmd_t                 dec;

    // Decode the kind field
    always_comb
    begin
        dec.id = task_id;
        unique case (kind)
            KIND_ENQ: dec.op = OP_ENQ;
            KIND_SVC: dec.op = OP_SVC;
            KIND_CAN: dec.op = OP_CAN;
            default:  dec.op = OP_BAD;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_wr     = push && !full;
    assign do_rd     = cmd_take && cmd_valid;
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_due   = q_due_reg[rd_ptr_reg];
    assign cmd_now   = q_now_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_cmd_reg[wr_ptr_reg] <= dec;
            q_due_reg[wr_ptr_reg] <= due_time;
            q_now_reg[wr_ptr_reg] <= current_time;
        end
    end

endmodule

// File: rtl/core/dotq_back.sv
// ----------------------------------------------------------------------------
// dotq_back
// Sorted slot cells and the sequencer that carries out each command,
// with a two-entry result queue.
// ----------------------------------------------------------------------------
module dotq_back #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  dotq_pkg::cmd_t                  cmd,
    input  logic [TIME_BITS-1:0]            cmd_due,
    input  logic [TIME_BITS-1:0]            cmd_now,
    output logic                            cmd_take,
    input  logic [dotq_pkg::CLICK_BITS-1:0] clip_limit,
    output logic                            res_valid,
    output dotq_pkg::res_t                  res,
    input  logic                            res_take
);
    import dotq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [TIME_BITS-1:0] due_reg [DEPTH];
    logic [ID_BITS-1:0]   id_reg  [DEPTH];
    logic [CW-1:0]        count_reg, count_next;
    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [ID_BITS-1:0]   rq_id_reg;

    res_t       rq_reg [2];
    logic       rwr_reg, rrd_reg;
    logic [1:0] rcnt_reg;
    logic       space;

    logic [DEPTH-1:0]     le, match, pre;
    logic [TIME_BITS-1:0] ins_due, due_m;
    logic [ID_BITS-1:0]   ins_id;
    logic                 any_match, q_full, head_due;
    logic                 ins_en, pop_en, rem_en, push_res, latch;
    res_t                 res_new;

    function automatic logic [CLICK_BITS-1:0] compare_for(
        input logic [TIME_BITS-1:0]  due,
        input logic [TIME_BITS-1:0]  now,
        input logic [CLICK_BITS-1:0] mx
    );
        logic [TIME_BITS-1:0] rem;
        rem = (due > now) ? (due - now) : '0;
        if (rem < TIME_BITS'(mx))
            compare_for = rem[CLICK_BITS-1:0];
        else
            compare_for = mx;
    endfunction

    // Insert key: the latched cancel in requeue, the command otherwise
    assign ins_due = (state_reg == ST_REQUEUE) ? now_reg   : cmd_due;
    assign ins_id  = (state_reg == ST_REQUEUE) ? rq_id_reg : cmd.id;

    // Per-cell compares and the prefix of the id match
    always_comb
    begin
        due_m = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            le[i]    = (CW'(i) < count_reg) && (due_reg[i] <= ins_due);
            match[i] = (CW'(i) < count_reg) && (id_reg[i] == cmd.id);
            pre[i]   = (i == 0) ? match[i] : (pre[i-1] | match[i]);
            if (match[i])
                due_m = due_m | due_reg[i];
        end
    end

    assign any_match = pre[DEPTH-1];
    assign q_full    = (count_reg == CW'(DEPTH));
    assign head_due  = (count_reg != '0) && (due_reg[0] <= now_reg);
    assign space     = (rcnt_reg != 2'd2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid && space)
                begin
                    if (cmd.op == OP_SVC)
                        state_next = ST_SERVICE;
                    else if (cmd.op == OP_CAN && any_match && (cmd_now < due_m))
                        state_next = ST_REQUEUE;
                end
            ST_SERVICE:
                if (space && !head_due)
                    state_next = ST_IDLE;
            ST_REQUEUE:
                if (space)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_take = 1'b0;
        ins_en   = 1'b0;
        pop_en   = 1'b0;
        rem_en   = 1'b0;
        push_res = 1'b0;
        latch    = 1'b0;
        res_new  = '{kind: RK_REJECT, id: '0, cmp: '0, last: 1'b1};
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid && space)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.op)
                        OP_ENQ:
                        begin
                            push_res = 1'b1;
                            if (!q_full && !any_match)
                            begin
                                ins_en = 1'b1;
                                if (!le[0])
                                begin
                                    res_new.kind = RK_ARMED;
                                    res_new.cmp  = compare_for(cmd_due, cmd_now, clip_limit);
                                end
                                else
                                    res_new.kind = RK_QUEUED;
                            end
                        end
                        OP_SVC:
                            latch = 1'b1;
                        OP_CAN:
                        begin
                            if (!any_match)
                                push_res = 1'b1;
                            else if (!(cmd_now < due_m))
                            begin
                                push_res     = 1'b1;
                                res_new.kind = RK_QUEUED;
                            end
                            else
                            begin
                                rem_en = 1'b1;
                                latch  = 1'b1;
                            end
                        end
                        default:
                            push_res = 1'b1;
                    endcase
                end
            ST_SERVICE:
                if (space)
                begin
                    push_res = 1'b1;
                    if (head_due)
                    begin
                        pop_en       = 1'b1;
                        res_new.kind = RK_DUE;
                        res_new.id   = id_reg[0];
                        res_new.last = 1'b0;
                    end
                    else if (count_reg != '0)
                    begin
                        res_new.kind = RK_ARMED;
                        res_new.cmp  = compare_for(due_reg[0], now_reg, clip_limit);
                    end
                    else
                        res_new.kind = RK_EMPTY;
                end
            ST_REQUEUE:
                if (space)
                begin
                    push_res     = 1'b1;
                    ins_en       = 1'b1;
                    res_new.kind = le[0] ? RK_QUEUED : RK_ARMED;
                end
            default:
                ;
        endcase
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (ins_en)
            count_next = count_reg + CW'(1);
        else if (pop_en || rem_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Latch time and id for multi-cycle commands
    always_ff @(posedge clk)
    begin
        if (latch)
        begin
            now_reg   <= cmd_now;
            rq_id_reg <= cmd.id;
        end
    end

    // Shift the slot cells
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ins_en && !le[i])
            begin
                if (i == 0 || le[(i == 0) ? 0 : i-1])
                begin
                    due_reg[i] <= ins_due;
                    id_reg[i]  <= ins_id;
                end
                else
                begin
                    due_reg[i] <= due_reg[(i == 0) ? 0 : i-1];
                    id_reg[i]  <= id_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if ((pop_en || (rem_en && pre[i])) && i < DEPTH-1)
            begin
                due_reg[i] <= due_reg[(i < DEPTH-1) ? i+1 : i];
                id_reg[i]  <= id_reg[(i < DEPTH-1) ? i+1 : i];
            end
        end
    end

    // Result queue
    assign res_valid = (rcnt_reg != 2'd0);
    assign res       = rq_reg[rrd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rwr_reg  <= 1'b0;
            rrd_reg  <= 1'b0;
            rcnt_reg <= 2'd0;
        end
        else
        begin
            rwr_reg  <= rwr_reg ^ push_res;
            rrd_reg  <= rrd_reg ^ (res_take && res_valid);
            rcnt_reg <= rcnt_reg + {1'b0, push_res} - {1'b0, res_take && res_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_res)
            rq_reg[rwr_reg] <= res_new;
    end

endmodule

// File: rtl/core/deadline_ordered_timer_queue_top.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_top
// Deadline-ordered timer queue with a one-shot compare output.
// ----------------------------------------------------------------------------
// Push an item when full is low; pop results while empty is low. An enqueue,
// a cancel that does not requeue and an unused kind give their single result
// when the sequencer takes the item from the front queue, and it is
// registered in the result queue; a cancel that requeues first removes the
// task and gives its result from the requeue state. A service item first
// latches the time and then yields one result per cycle while the result
// queue has space, one per due task plus a final one. Each item is carried
// out by the single sequencer over the sorted slot cells, which shift by one
// place per cycle. Results wait in a two-entry queue and the sequencer stalls
// while it is full; a two-entry front queue holds further input beats meanwhile.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue_top #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      kind,
    input  logic [dotq_pkg::ID_BITS-1:0]    task_id,
    input  logic [TIME_BITS-1:0]            due_time,
    input  logic [TIME_BITS-1:0]            current_time,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      result_kind,
    output logic [dotq_pkg::ID_BITS-1:0]    due_task_id,
    output logic [dotq_pkg::CLICK_BITS-1:0] compare_clicks,
    output logic                            last_result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dotq_pkg::CLICK_BITS-1:0] cfg_data
);
    import dotq_pkg::*;

    logic [CLICK_BITS-1:0] clip_limit_reg;
    logic                  cmd_valid, cmd_take, res_valid;
    cmd_t                  cmd;
    logic [TIME_BITS-1:0]  cmd_due, cmd_now;
    res_t                  res;

    // Hold the compare limit
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clip_limit_reg <= '1;
        else if (cfg_valid)
            clip_limit_reg <= cfg_data;
    end

    dotq_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .task_id      (task_id),
        .due_time     (due_time),
        .current_time (current_time),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_due      (cmd_due),
        .cmd_now      (cmd_now),
        .cmd_take     (cmd_take)
    );

    dotq_back #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_due    (cmd_due),
        .cmd_now    (cmd_now),
        .cmd_take   (cmd_take),
        .clip_limit (clip_limit_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (pop)
    );

    assign empty          = !res_valid;
    assign result_kind    = res.kind;
    assign due_task_id    = res.id;
    assign compare_clicks = res.cmp;
    assign last_result    = res.last;

endmodule

// File: rtl/core/dotq_checker.sv
// ----------------------------------------------------------------------------
// dotq_checker
// Port-level checks of the result channel of the timer queue.
// ----------------------------------------------------------------------------
module dotq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  result_kind,
    input logic [3:0]  due_task_id,
    input logic [15:0] compare_clicks,
    input logic        last_result
);
    import dotq_pkg::*;

    // Due results are never the final beat of an item
    a_due_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == RK_DUE) |-> !last_result)
        else $error("due result marked last");

    // Only due results carry a task id
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != RK_DUE) |-> (due_task_id == 4'd0))
        else $error("task id on non-due result");

    // Only armed results carry a compare value
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != RK_ARMED) |-> (compare_clicks == 16'd0))
        else $error("compare value on non-armed result");

    // The kind and last flag of a waiting result hold until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(last_result)))
        else $error("waiting result changed");

endmodule

bind deadline_ordered_timer_queue_top dotq_checker u_chk (.*);
